// ----- src/bcie_pkg.sv -----
package bcie_pkg;

  localparam int RAM_DEPTH   = 256;
  localparam int STACK_DEPTH = 256;
  localparam int RAM_AW      = $clog2(RAM_DEPTH);
  localparam int SP_W        = $clog2(STACK_DEPTH);
  localparam int NUM_REGS    = 10;
  localparam int REG_IW      = $clog2(NUM_REGS);
  localparam int LEN_W       = 9;
  localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(256);

  localparam int REG_OUT  = 5;
  localparam int REG_ADDR = 6;
  localparam int REG_PC   = 9;

  localparam logic [7:0] SEL_ZERO  = 8'd0;
  localparam logic [7:0] SEL_ADDR  = 8'd6;
  localparam logic [7:0] SEL_RAM   = 8'd7;
  localparam logic [7:0] SEL_STACK = 8'd8;
  localparam logic [7:0] SEL_PC    = 8'd9;

  localparam logic [5:0] OP_ADD  = 6'd0;
  localparam logic [5:0] OP_SUB  = 6'd1;
  localparam logic [5:0] OP_OR   = 6'd2;
  localparam logic [5:0] OP_NOR  = 6'd3;
  localparam logic [5:0] OP_AND  = 6'd4;
  localparam logic [5:0] OP_NAND = 6'd5;
  localparam logic [5:0] OP_XOR  = 6'd6;
  localparam logic [5:0] OP_XNOR = 6'd7;
  localparam logic [5:0] OP_SHL  = 6'd8;
  localparam logic [5:0] OP_SHR  = 6'd9;
  localparam logic [5:0] OP_ROL  = 6'd10;
  localparam logic [5:0] OP_ROR  = 6'd11;
  localparam logic [5:0] OP_BEQ  = 6'd12;
  localparam logic [5:0] OP_BNE  = 6'd13;
  localparam logic [5:0] OP_BGE  = 6'd14;
  localparam logic [5:0] OP_BLT  = 6'd15;
  localparam logic [5:0] OP_BGT  = 6'd16;
  localparam logic [5:0] OP_BLE  = 6'd17;
  localparam logic [5:0] OP_BCS  = 6'd18;
  localparam logic [5:0] OP_BCC  = 6'd19;
  localparam logic [5:0] OP_BMI  = 6'd20;
  localparam logic [5:0] OP_BPL  = 6'd21;
  localparam logic [5:0] OP_BZS  = 6'd22;
  localparam logic [5:0] OP_BZC  = 6'd23;
  localparam logic [5:0] OP_HALT = 6'd63;

  localparam logic [1:0] RS_RUN     = 2'd0;
  localparam logic [1:0] RS_HALT    = 2'd1;
  localparam logic [1:0] RS_INVALID = 2'd2;
  localparam logic [1:0] RS_RANGE   = 2'd3;

  typedef struct packed {
    logic [7:0] dest_select;
    logic [7:0] src_a;
    logic [7:0] src_b;
    logic [5:0] opcode;
    logic       a_is_immediate;
    logic       b_is_immediate;
  } in_item_t;

  typedef struct packed {
    logic [7:0] next_pc;
    logic [1:0] run_state;
    logic [7:0] written_value;
    logic       carry_flag;
    logic       zero_flag;
    logic       negative_flag;
    logic [7:0] reg_five;
  } out_item_t;

  typedef struct packed {
    logic carry;
    logic zero;
    logic negative;
  } flags_t;

  typedef struct packed {
    logic [7:0] value;
    logic       carry;
    logic       take;
  } alu_out_t;

endpackage

// ----- src/bcie_ram.sv -----
module bcie_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- src/bcie_alu.sv -----
module bcie_alu import bcie_pkg::*; (
  input  logic [5:0] opcode,
  input  logic [7:0] a,
  input  logic [7:0] b,
  input  flags_t     flags,
  output alu_out_t   res
);

  logic [8:0] sum;

  assign sum = {1'b0, a} + {1'b0, b};

  always_comb begin
    res = '0;
    unique case (opcode)
      OP_ADD: begin
        res.value = sum[7:0];
        res.carry = sum[8];
      end
      OP_SUB: begin
        res.value = a - b;
        res.carry = (a >= b);
      end
      OP_OR:   res.value = a | b;
      OP_NOR:  res.value = ~(a | b);
      OP_AND:  res.value = a & b;
      OP_NAND: res.value = ~(a & b);
      OP_XOR:  res.value = a ^ b;
      OP_XNOR: res.value = ~(a ^ b);
      OP_SHL: begin
        res.value = {a[6:0], 1'b0};
        res.carry = a[7];
      end
      OP_SHR: begin
        res.value = {1'b0, a[7:1]};
        res.carry = a[0];
      end
      OP_ROL: begin
        res.value = {a[6:0], a[7]};
        res.carry = a[7];
      end
      OP_ROR: begin
        res.value = {a[0], a[7:1]};
        res.carry = a[0];
      end
      OP_BEQ: res.take = (a == b);
      OP_BNE: res.take = (a != b);
      OP_BGE: res.take = (a >= b);
      OP_BLT: res.take = (a < b);
      OP_BGT: res.take = (a > b);
      OP_BLE: res.take = (a <= b);
      OP_BCS: res.take = flags.carry;
      OP_BCC: res.take = !flags.carry;
      OP_BMI: res.take = flags.negative;
      OP_BPL: res.take = !flags.negative;
      OP_BZS: res.take = flags.zero;
      OP_BZC: res.take = !flags.zero;
      default: res = '0;
    endcase
  end

endmodule

// ----- src/byte_cpu_instruction_execute_core.sv -----
// executes one instruction of a small 8-bit machine per input item
// input channel: in_valid / in_stall / in_item (fields of one instruction)
// result channel: out_valid / out_stall / out_item (pc, run state, value, flags, reg 5)
// config: cfg_wr_en / cfg_wr_data write program_length; user must do so only while the block is idle, not enforced
// each item passes a read phase, which reads the data ram and the first stack pop, and
// an execute phase, which reads the second stack pop and ends in the write-back; the
// stack ram has a single read port, which is why the two pops are split
// a result is registered in the output register at the write-back of its item
// the block takes no new item while one is in flight; the next item is accepted at
// the same edge at which the previous one writes back
// the output register holds a result while out_stall is high; the write-back waits
// for it to drain, so a stalled receiver stalls the input after one item
// reset: registers, stack pointer and flags cleared (zero flag set), running state,
// program_length 256; data and stack ram hold no defined contents until written,
// and no clearing pass is run
module byte_cpu_instruction_execute_core import bcie_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  in_item_t         in_item,
  output logic             out_valid,
  input  logic             out_stall,
  output out_item_t        out_item,
  input  logic             cfg_wr_en,
  input  logic [LEN_W-1:0] cfg_wr_data
);

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_READ = 2'd1;
  localparam logic [1:0] PH_EXEC = 2'd2;

  logic [1:0]       phase_r, phase_nxt;
  in_item_t         inst_r;
  logic [7:0]       regs_r [NUM_REGS];
  logic [SP_W-1:0]  sp_r, sp_nxt;
  flags_t           flags_r, flags_nxt;
  logic [1:0]       stop_r, stop_nxt;
  logic [LEN_W-1:0] len_r;

  logic             ram_hit_r, stk_hit_r;
  logic [7:0]       ram_fwd_r, stk_fwd_r;
  logic [7:0]       ram_q_r, pop_a_r;

  logic             out_valid_r;
  out_item_t        out_item_r;

  logic             accept, commit;
  logic             a_pop, b_pop, pre_range, run;
  logic             is_alu, is_br;
  logic [1:0]       pops;
  logic [SP_W-1:0]  sp_popped, sp_eff;
  logic [7:0]       op_a, op_b, written, pc_nxt, reg6_nxt, reg5_nxt;
  logic             reg_we, ram_we, stk_we;
  alu_out_t         alu_res;

  logic [RAM_AW-1:0] ram_raddr, ram_waddr;
  logic [SP_W-1:0]   stk_raddr, stk_waddr;
  logic [7:0]        ram_rdata, stk_rdata;

  assign commit   = (phase_r == PH_EXEC) && (!out_valid_r || !out_stall);
  assign in_stall = !((phase_r == PH_IDLE) || commit);
  assign accept   = in_valid && !in_stall;

  assign a_pop = !inst_r.a_is_immediate && (inst_r.src_a == SEL_STACK);
  assign b_pop = !inst_r.b_is_immediate && (inst_r.src_b == SEL_STACK);
  assign pops  = {1'b0, a_pop} + {1'b0, b_pop};
  assign sp_popped = sp_r - SP_W'(pops);

  assign pre_range = ({1'b0, regs_r[REG_PC]} >= len_r);
  assign run       = (stop_r == RS_RUN) && !pre_range;
  assign is_alu    = (inst_r.opcode <= OP_ROR);
  assign is_br     = (inst_r.opcode >= OP_BEQ) && (inst_r.opcode <= OP_BZC);

  always_comb begin
    if (inst_r.a_is_immediate) begin
      op_a = inst_r.src_a;
    end else if (a_pop) begin
      op_a = pop_a_r;
    end else if (inst_r.src_a == SEL_RAM) begin
      op_a = ram_q_r;
    end else if (inst_r.src_a <= SEL_PC) begin
      op_a = regs_r[inst_r.src_a[REG_IW-1:0]];
    end else begin
      op_a = '0;
    end
    if (inst_r.b_is_immediate) begin
      op_b = inst_r.src_b;
    end else if (b_pop) begin
      op_b = stk_rdata;
    end else if (inst_r.src_b == SEL_RAM) begin
      op_b = ram_q_r;
    end else if (inst_r.src_b <= SEL_PC) begin
      op_b = regs_r[inst_r.src_b[REG_IW-1:0]];
    end else begin
      op_b = '0;
    end
  end

  bcie_alu u_alu (
    .opcode (inst_r.opcode),
    .a      (op_a),
    .b      (op_b),
    .flags  (flags_r),
    .res    (alu_res)
  );

  always_comb begin
    sp_nxt    = sp_r;
    flags_nxt = flags_r;
    stop_nxt  = stop_r;
    written   = '0;
    reg_we    = 1'b0;
    ram_we    = 1'b0;
    stk_we    = 1'b0;
    pc_nxt    = regs_r[REG_PC];
    if ((stop_r == RS_RUN) && pre_range) begin
      stop_nxt = RS_RANGE;
    end
    if (run) begin
      sp_nxt = sp_popped;
      if (is_alu) begin
        written   = alu_res.value;
        flags_nxt = '{carry: alu_res.carry, zero: (alu_res.value == 8'd0),
                      negative: alu_res.value[7]};
        if (inst_r.dest_select == SEL_STACK) begin
          stk_we = 1'b1;
          sp_nxt = sp_popped + SP_W'(1);
        end else if (inst_r.dest_select == SEL_RAM) begin
          ram_we = 1'b1;
        end else if ((inst_r.dest_select != SEL_ZERO) && (inst_r.dest_select <= SEL_ADDR)) begin
          reg_we = 1'b1;
        end
        pc_nxt = ((inst_r.dest_select == SEL_PC) ? alu_res.value : regs_r[REG_PC]) + 8'd1;
      end else if (is_br) begin
        pc_nxt = alu_res.take ? regs_r[REG_ADDR] : regs_r[REG_PC] + 8'd1;
      end else if (inst_r.opcode == OP_HALT) begin
        stop_nxt = RS_HALT;
      end else begin
        stop_nxt = RS_INVALID;
      end
      if ((is_alu || is_br) && ({1'b0, pc_nxt} >= len_r)) begin
        stop_nxt = RS_RANGE;
      end
    end
  end

  assign reg6_nxt = (commit && reg_we && (inst_r.dest_select == SEL_ADDR)) ?
                    written : regs_r[REG_ADDR];
  assign reg5_nxt = (reg_we && (inst_r.dest_select == 8'(REG_OUT))) ? written : regs_r[REG_OUT];
  assign sp_eff   = commit ? sp_nxt : sp_r;

  // address forwarding so the next item reads what this write-back leaves
  // second pop address is held while the item waits in execute
  assign ram_waddr = regs_r[REG_ADDR][RAM_AW-1:0];
  assign ram_raddr = reg6_nxt[RAM_AW-1:0];
  assign stk_waddr = sp_popped;
  assign stk_raddr = ((phase_r == PH_READ) || ((phase_r == PH_EXEC) && !commit)) ?
                     (sp_r - SP_W'(1) - SP_W'(a_pop)) : (sp_eff - SP_W'(1));

  bcie_ram #(.WIDTH(8), .DEPTH(RAM_DEPTH)) u_data_ram (
    .clk   (clk),
    .we    (commit && ram_we),
    .waddr (ram_waddr),
    .wdata (written),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  bcie_ram #(.WIDTH(8), .DEPTH(STACK_DEPTH)) u_stack_ram (
    .clk   (clk),
    .we    (commit && stk_we),
    .waddr (stk_waddr),
    .wdata (written),
    .raddr (stk_raddr),
    .rdata (stk_rdata)
  );

  always_comb begin
    phase_nxt = phase_r;
    unique case (phase_r)
      PH_IDLE: begin
        if (accept) begin
          phase_nxt = PH_READ;
        end
      end
      PH_READ: phase_nxt = PH_EXEC;
      PH_EXEC: begin
        if (commit) begin
          phase_nxt = accept ? PH_READ : PH_IDLE;
        end
      end
      default: phase_nxt = PH_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      sp_r        <= '0;
      flags_r     <= '{carry: 1'b0, zero: 1'b1, negative: 1'b0};
      stop_r      <= RS_RUN;
      len_r       <= LEN_RESET;
      out_valid_r <= 1'b0;
      for (int i = 0; i < NUM_REGS; i++) begin
        regs_r[i] <= '0;
      end
    end else begin
      phase_r <= phase_nxt;
      if (cfg_wr_en) begin
        len_r <= cfg_wr_data;
      end
      if (commit) begin
        sp_r           <= sp_nxt;
        flags_r        <= flags_nxt;
        stop_r         <= stop_nxt;
        regs_r[REG_PC] <= pc_nxt;
        if (reg_we) begin
          regs_r[inst_r.dest_select[REG_IW-1:0]] <= written;
        end
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      inst_r    <= in_item;
      ram_hit_r <= commit && ram_we && (ram_waddr == ram_raddr);
      stk_hit_r <= commit && stk_we && (stk_waddr == stk_raddr);
      ram_fwd_r <= written;
      stk_fwd_r <= written;
    end
    if (phase_r == PH_READ) begin
      ram_q_r <= ram_hit_r ? ram_fwd_r : ram_rdata;
      pop_a_r <= stk_hit_r ? stk_fwd_r : stk_rdata;
    end
    if (commit) begin
      out_item_r <= '{next_pc: pc_nxt, run_state: stop_nxt, written_value: written,
                      carry_flag: flags_nxt.carry, zero_flag: flags_nxt.zero,
                      negative_flag: flags_nxt.negative, reg_five: reg5_nxt};
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  a_accept_reads: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (phase_r == PH_READ))
    else $error("accepted item did not enter the read cycle");

  a_read_to_exec: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_READ) |=> (phase_r == PH_EXEC))
    else $error("read cycle not followed by execute");

  a_stop_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    (stop_r != RS_RUN) |=> (stop_r == $past(stop_r)))
    else $error("stopped machine left its stop state");

  a_stopped_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (commit && !run) |=> ($stable(sp_r) && $stable(regs_r[REG_PC])
                          && $stable(regs_r[REG_ADDR])))
    else $error("state changed by an instruction that did not run");

  a_commit_out: assert property (@(posedge clk) disable iff (!rst_n)
    commit |=> out_valid_r)
    else $error("write-back without a result");

endmodule

// ----- test/tb_byte_cpu_instruction_execute_core.sv -----
module tb_byte_cpu_instruction_execute_core import bcie_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IN_W = $bits(in_item_t);

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_stall;
  in_item_t         in_item = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  out_item_t        out_item;
  logic             cfg_wr_en = 1'b0;
  logic [LEN_W-1:0] cfg_wr_data = '0;

  byte_cpu_instruction_execute_core dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_item(in_item),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item(out_item),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // machine state as the testbench sees it
  bit [7:0]       arch_regs [0:9];
  bit [7:0]       ram_img [0:255];
  bit             ram_written [0:255];
  bit [7:0]       stack_img [0:255];
  bit             stack_written [0:255];
  bit [7:0]       stack_ptr;
  bit             flag_c;
  bit             flag_z = 1'b1;
  bit             flag_n;
  bit [1:0]       run_st = RS_RUN;
  bit [LEN_W-1:0] prog_len = LEN_RESET;

  out_item_t      pending_retire [$];
  out_item_t      want_res;
  int unsigned    mismatches;
  int unsigned    results_seen;
  bit             stop_ok;
  bit             idle_off;
  int unsigned    hold_req;
  int unsigned    stall_left;
  bit             stall_on;

  function automatic int unsigned pick_idle();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (idle_off) return 0;
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  function automatic bit [7:0] operand(input bit [7:0] sel, input bit imm,
                                       input bit [7:0] addr, inout bit [7:0] sp_l);
    if (imm) return sel;
    if (sel == SEL_STACK) begin
      sp_l = sp_l - 8'd1;
      return stack_img[sp_l];
    end
    if (sel == SEL_RAM) return ram_img[addr];
    if (sel > SEL_PC) return 8'd0;
    return arch_regs[sel];
  endfunction

  // runs one instruction on the local machine copy; state is only updated when commit is set
  function automatic out_item_t exec_instr(input in_item_t it, input bit commit);
    bit [7:0] a, b, addr, pc, val, nxt, sp_l, r5;
    bit [8:0] wide;
    bit       c, z, n, take;
    bit [1:0] st;
    out_item_t res;
    st = run_st;
    c = flag_c;
    z = flag_z;
    n = flag_n;
    sp_l = stack_ptr;
    val = 8'd0;
    nxt = arch_regs[REG_PC];
    r5 = arch_regs[REG_OUT];
    if (st == RS_RUN && {1'b0, arch_regs[REG_PC]} >= prog_len) st = RS_RANGE;
    if (st == RS_RUN) begin
      addr = arch_regs[REG_ADDR];
      a = operand(it.src_a, it.a_is_immediate, addr, sp_l);
      b = operand(it.src_b, it.b_is_immediate, addr, sp_l);
      pc = arch_regs[REG_PC];
      if (it.opcode <= OP_ROR) begin
        c = 1'b0;
        case (it.opcode)
          OP_ADD: begin
            wide = {1'b0, a} + {1'b0, b};
            val = wide[7:0];
            c = wide[8];
          end
          OP_SUB: begin
            val = a - b;
            c = (a >= b);
          end
          OP_OR:   val = a | b;
          OP_NOR:  val = ~(a | b);
          OP_AND:  val = a & b;
          OP_NAND: val = ~(a & b);
          OP_XOR:  val = a ^ b;
          OP_XNOR: val = ~(a ^ b);
          OP_SHL: begin
            val = {a[6:0], 1'b0};
            c = a[7];
          end
          OP_SHR: begin
            val = {1'b0, a[7:1]};
            c = a[0];
          end
          OP_ROL: begin
            val = {a[6:0], a[7]};
            c = a[7];
          end
          default: begin
            val = {a[0], a[7:1]};
            c = a[0];
          end
        endcase
        z = (val == 8'd0);
        n = val[7];
        if (it.dest_select == SEL_PC) pc = val;
        if (it.dest_select == 8'(REG_OUT)) r5 = val;
        nxt = pc + 8'd1;
        if (commit) begin
          if (it.dest_select == SEL_STACK) begin
            stack_img[sp_l] = val;
            stack_written[sp_l] = 1'b1;
            sp_l = sp_l + 8'd1;
          end else if (it.dest_select == SEL_RAM) begin
            ram_img[addr] = val;
            ram_written[addr] = 1'b1;
          end else if (it.dest_select != SEL_ZERO && it.dest_select <= SEL_PC) begin
            arch_regs[it.dest_select] = val;
          end
        end
      end else if (it.opcode <= OP_BZC) begin
        case (it.opcode)
          OP_BEQ:  take = (a == b);
          OP_BNE:  take = (a != b);
          OP_BGE:  take = (a >= b);
          OP_BLT:  take = (a < b);
          OP_BGT:  take = (a > b);
          OP_BLE:  take = (a <= b);
          OP_BCS:  take = c;
          OP_BCC:  take = !c;
          OP_BMI:  take = n;
          OP_BPL:  take = !n;
          OP_BZS:  take = z;
          default: take = !z;
        endcase
        nxt = take ? arch_regs[REG_ADDR] : pc + 8'd1;
      end else if (it.opcode == OP_HALT) begin
        st = RS_HALT;
      end else begin
        st = RS_INVALID;
      end
      if (st == RS_RUN && {1'b0, nxt} >= prog_len) st = RS_RANGE;
    end
    if (commit) begin
      arch_regs[REG_PC] = nxt;
      stack_ptr = sp_l;
      flag_c = c;
      flag_z = z;
      flag_n = n;
      run_st = st;
    end
    res.next_pc = nxt;
    res.run_state = st;
    res.written_value = val;
    res.carry_flag = c;
    res.zero_flag = z;
    res.negative_flag = n;
    res.reg_five = r5;
    return res;
  endfunction

  function automatic bit readable(input bit [7:0] sel, inout bit [7:0] sp_l);
    if (sel == SEL_RAM) return ram_written[arch_regs[REG_ADDR]];
    if (sel != SEL_STACK) return 1'b1;
    if (!stack_written[8'(sp_l - 8'd1)]) return 1'b0;
    sp_l = sp_l - 8'd1;
    return 1'b1;
  endfunction

  // alu write of 0xff to the pc, which then wraps to zero
  function automatic in_item_t rewind_item(input in_item_t it);
    it.dest_select = SEL_PC;
    it.opcode = OP_OR;
    it.src_a = 8'hFF;
    it.a_is_immediate = 1'b1;
    it.b_is_immediate = 1'b1;
    return it;
  endfunction

  // never read memory that was not written; keep the machine running until the stop test
  function automatic in_item_t shape_item(input in_item_t it);
    bit [7:0] sp_l;
    out_item_t trial;
    if (run_st == RS_RUN && {1'b0, arch_regs[REG_PC]} < prog_len) begin
      sp_l = stack_ptr;
      if (!it.a_is_immediate && !readable(it.src_a, sp_l)) it.a_is_immediate = 1'b1;
      if (!it.b_is_immediate && !readable(it.src_b, sp_l)) it.b_is_immediate = 1'b1;
    end
    if (!stop_ok) begin
      trial = exec_instr(it, 1'b0);
      if (trial.run_state != RS_RUN) it = rewind_item(it);
    end
    return it;
  endfunction

  function automatic bit [7:0] pick_source(output bit imm);
    int unsigned r;
    r = $urandom_range(0, 99);
    imm = (r < 40);
    if (imm) return 8'($urandom);
    r = $urandom_range(0, 99);
    if (r < 20) return SEL_STACK;
    if (r < 40) return SEL_RAM;
    if (r < 90) return 8'($urandom_range(0, 9));
    return 8'($urandom);
  endfunction

  function automatic in_item_t rand_instr();
    in_item_t it;
    bit ia, ib;
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 30) it.dest_select = SEL_STACK;
    else if (r < 45) it.dest_select = SEL_RAM;
    else if (r < 50) it.dest_select = SEL_PC;
    else if (r < 85) it.dest_select = 8'($urandom_range(0, 6));
    else it.dest_select = 8'($urandom);
    it.src_a = pick_source(ia);
    it.src_b = pick_source(ib);
    it.a_is_immediate = ia;
    it.b_is_immediate = ib;
    if ($urandom_range(0, 99) < 88) it.opcode = 6'($urandom_range(0, 23));
    else it.opcode = 6'($urandom_range(0, 63));
    return it;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    mismatches++;
    if (mismatches <= 50)
      $display("mismatch on %s at result %0d: got %0h expected %0h",
               what, results_seen, got, want);
  endtask

  always @(posedge clk) begin
    if (hold_req != 0) begin
      stall_on = 1'b1;
      stall_left = hold_req;
      hold_req = 0;
    end else if (stall_left != 0) begin
      stall_left--;
    end else begin
      stall_on = !idle_off && ($urandom_range(0, 2) == 0);
      stall_left = stall_on ? pick_idle() : $urandom_range(0, 8);
    end
    out_stall <= stall_on;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_retire.size() == 0) begin
        report_mismatch("result with nothing pending, next_pc", out_item.next_pc, 0);
      end else begin
        want_res = pending_retire.pop_front();
        if (out_item.next_pc !== want_res.next_pc)
          report_mismatch("next_pc", out_item.next_pc, want_res.next_pc);
        if (out_item.run_state !== want_res.run_state)
          report_mismatch("run_state", out_item.run_state, want_res.run_state);
        if (out_item.written_value !== want_res.written_value)
          report_mismatch("written_value", out_item.written_value, want_res.written_value);
        if (out_item.carry_flag !== want_res.carry_flag)
          report_mismatch("carry_flag", out_item.carry_flag, want_res.carry_flag);
        if (out_item.zero_flag !== want_res.zero_flag)
          report_mismatch("zero_flag", out_item.zero_flag, want_res.zero_flag);
        if (out_item.negative_flag !== want_res.negative_flag)
          report_mismatch("negative_flag", out_item.negative_flag, want_res.negative_flag);
        if (out_item.reg_five !== want_res.reg_five)
          report_mismatch("reg_five", out_item.reg_five, want_res.reg_five);
      end
      results_seen++;
    end
  end

  task automatic send_item(input in_item_t raw);
    in_item_t it;
    out_item_t want;
    int unsigned gap;
    it = shape_item(raw);
    want = exec_instr(it, 1'b1);
    gap = pick_idle();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_retire.push_back(want);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_retire.size() != 0) @(posedge clk);
  endtask

  task automatic write_length(input bit [LEN_W-1:0] len);
    drain();
    repeat (2) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= len;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    prog_len = len;
  endtask

  // bring the pc back below the new length first
  task automatic set_length(input bit [LEN_W-1:0] len);
    if ({1'b0, arch_regs[REG_PC]} >= len) send_item(rewind_item(rand_instr()));
    write_length(len);
  endtask

  task automatic test_directed();
    bit [7:0] corner_vals [5] = '{8'h00, 8'hFF, 8'h80, 8'h7F, 8'h01};
    bit [7:0] dest_list [8] = '{SEL_STACK, SEL_STACK, 8'd5, SEL_RAM, SEL_PC, SEL_ZERO,
                                8'd250, SEL_ADDR};
    in_item_t it;
    for (int k = 0; k <= int'(OP_BZC); k++) begin
      it.opcode = 6'(k);
      it.src_a = corner_vals[k % 5];
      it.src_b = corner_vals[(k + 2) % 5];
      it.a_is_immediate = (k % 3 != 2);
      it.b_is_immediate = (k % 4 != 3);
      if (!it.a_is_immediate) it.src_a = (k % 2 == 1) ? SEL_STACK : SEL_RAM;
      if (!it.b_is_immediate) it.src_b = SEL_STACK;
      it.dest_select = dest_list[k % 8];
      send_item(it);
    end
  endtask

  task automatic test_lengths();
    bit [LEN_W-1:0] lens [4] = '{9'd255, 9'd128, 9'd16, 9'd1};
    foreach (lens[k]) begin
      set_length(lens[k]);
      repeat (50) send_item(rand_instr());
    end
    write_length(9'd0);
    write_length(LEN_RESET);
  endtask

  task automatic test_random();
    repeat (1450) send_item(rand_instr());
  endtask

  task automatic test_back_to_back();
    idle_off <= 1'b1;
    repeat (80) send_item(rand_instr());
    idle_off <= 1'b0;
  endtask

  task automatic test_pressure();
    drain();
    @(negedge clk);
    hold_req = 200;
    @(posedge clk);
    repeat (40) send_item(rand_instr());
    drain();
    repeat (40) send_item(rand_instr());
  endtask

  // the machine stops for good here: halt, invalid opcode, or pc out of range
  task automatic test_stop();
    in_item_t it;
    int unsigned kind;
    kind = $urandom_range(0, 2);
    stop_ok = 1'b1;
    it = rand_instr();
    if (kind == 2) begin
      if (arch_regs[REG_PC] != 8'hFF && $urandom_range(0, 1) == 1) begin
        write_length({1'b0, arch_regs[REG_PC]} + 9'd1);
        it.opcode = OP_ADD;
        it.dest_select = 8'(REG_OUT);
      end else begin
        write_length(9'($urandom_range(0, arch_regs[REG_PC])));
      end
    end else if (kind == 1) begin
      it.opcode = 6'($urandom_range(int'(OP_BZC) + 1, int'(OP_HALT) - 1));
    end else begin
      it.opcode = OP_HALT;
    end
    send_item(it);
    repeat (30) begin
      it = in_item_t'(IN_W'($urandom));
      send_item(it);
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_lengths();
    test_random();
    test_back_to_back();
    test_pressure();
    test_stop();
    drain();
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("FAILURE");
    $finish;
  end

endmodule
